@@ rtl/core/rotated_rect_collision_core_assert.svh @@
// Assertion macros for the rotated rectangle collision core
`ifndef ROTATED_RECT_COLLISION_CORE_ASSERT_SVH
`define ROTATED_RECT_COLLISION_CORE_ASSERT_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define RRC_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk_i, off during reset
`define RRC_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/rrc_pkg.sv @@
// Shared constants, types and sine lookup for the rectangle collision core
package rrc_pkg;

  localparam int DEG_FULL    = 360;
  localparam int DEG_HALF    = 180;
  localparam int DEG_QUARTER = 90;
  localparam int NUM_STAGES  = 8;
  localparam int TRIG_W      = 18;

  typedef logic [8:0]            angle_t;
  typedef logic [6:0]            quad_idx_t;
  typedef logic [NUM_STAGES:1]   stage_en_t;
  typedef logic signed [TRIG_W-1:0] trig_t;

  localparam logic [16:0] SINE_Q16 [0:90] = '{
    17'd0, 17'd1144, 17'd2287, 17'd3430, 17'd4572, 17'd5712, 17'd6850, 17'd7987,
    17'd9121, 17'd10252, 17'd11380, 17'd12505, 17'd13626, 17'd14742, 17'd15855,
    17'd16962, 17'd18064, 17'd19161, 17'd20252, 17'd21336, 17'd22415, 17'd23486,
    17'd24550, 17'd25607, 17'd26656, 17'd27697, 17'd28729, 17'd29753, 17'd30767,
    17'd31772, 17'd32768, 17'd33754, 17'd34729, 17'd35693, 17'd36647, 17'd37590,
    17'd38521, 17'd39441, 17'd40348, 17'd41243, 17'd42126, 17'd42995, 17'd43852,
    17'd44695, 17'd45525, 17'd46341, 17'd47143, 17'd47930, 17'd48703, 17'd49461,
    17'd50203, 17'd50931, 17'd51643, 17'd52339, 17'd53020, 17'd53684, 17'd54332,
    17'd54963, 17'd55578, 17'd56175, 17'd56756, 17'd57319, 17'd57865, 17'd58393,
    17'd58903, 17'd59396, 17'd59870, 17'd60326, 17'd60764, 17'd61183, 17'd61584,
    17'd61966, 17'd62328, 17'd62672, 17'd62997, 17'd63303, 17'd63589, 17'd63856,
    17'd64104, 17'd64332, 17'd64540, 17'd64729, 17'd64898, 17'd65048, 17'd65177,
    17'd65287, 17'd65376, 17'd65446, 17'd65496, 17'd65526, 17'd65536
  };

  function automatic logic [16:0] quarter_sine(input quad_idx_t d, input int trig_frac);
    logic [17:0] v;
    v = {1'b0, SINE_Q16[d]};
    if (trig_frac >= 16) begin
      return v[16:0];
    end
    return 17'((v + (18'd1 << (15 - trig_frac))) >> (16 - trig_frac));
  endfunction

  function automatic trig_t sine_deg(input angle_t a, input int trig_frac);
    logic [16:0] q;
    logic        neg;
    if (a <= angle_t'(DEG_QUARTER)) begin
      q   = quarter_sine(quad_idx_t'(a), trig_frac);
      neg = 1'b0;
    end else if (a <= angle_t'(DEG_HALF)) begin
      q   = quarter_sine(quad_idx_t'(angle_t'(DEG_HALF) - a), trig_frac);
      neg = 1'b0;
    end else if (a <= angle_t'(DEG_HALF + DEG_QUARTER)) begin
      q   = quarter_sine(quad_idx_t'(a - angle_t'(DEG_HALF)), trig_frac);
      neg = 1'b1;
    end else begin
      q   = quarter_sine(quad_idx_t'(angle_t'(DEG_FULL) - a), trig_frac);
      neg = 1'b1;
    end
    return neg ? -trig_t'({1'b0, q}) : trig_t'({1'b0, q});
  endfunction

endpackage

@@ rtl/core/rotated_rect_collision_core.sv @@
// Top level: oriented rectangle collision test, eight-stage pipeline
// Result: out_valid_o and overlap_o come from the stage 8 registers; a query passes stages 1 to 8 in order.
// Throughput: one query per cycle; a stage holds only while it and all later stages are full
// and the output waits. Bubbles close up under output backpressure, so input ready tracks
// free pipeline slots.
// Reset: rst_ni clears all stage valid bits; no result is presented after reset.
module rotated_rect_collision_core #(
  parameter int COORD_WIDTH     = 24,
  parameter int COORD_FRAC_BITS = 8,
  parameter int TRIG_FRAC_BITS  = 14
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [COORD_WIDTH-1:0] a_left_i,
  input  logic signed [COORD_WIDTH-1:0] a_top_i,
  input  logic [COORD_WIDTH-2:0]        a_width_i,
  input  logic [COORD_WIDTH-2:0]        a_height_i,
  input  rrc_pkg::angle_t               a_angle_i,
  input  logic signed [COORD_WIDTH-1:0] b_left_i,
  input  logic signed [COORD_WIDTH-1:0] b_top_i,
  input  logic [COORD_WIDTH-2:0]        b_width_i,
  input  logic [COORD_WIDTH-2:0]        b_height_i,
  input  rrc_pkg::angle_t               b_angle_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          overlap_o
);
  import rrc_pkg::*;

  `include "rotated_rect_collision_core_assert.svh"

  localparam int W   = COORD_WIDTH;
  localparam int CRW = W + 3;
  localparam int AXW = CRW + 1;

  stage_en_t en;
  stage_en_t v_q;
  logic [7:1] al_q, ah_q;
  logic       overlap_q;

  logic signed [CRW-1:0] cxa [4];
  logic signed [CRW-1:0] cya [4];
  logic signed [CRW-1:0] cxb [4];
  logic signed [CRW-1:0] cyb [4];
  logic signed [CRW-1:0] cx [8];
  logic signed [CRW-1:0] cy [8];
  logic signed [CRW-1:0] cx4_q [8];
  logic signed [CRW-1:0] cy4_q [8];
  logic signed [AXW-1:0] axx_q [4];
  logic signed [AXW-1:0] axy_q [4];
  logic [3:0]            sep;

  logic signed [W:0] a_r, a_b, b_r, b_b;
  logic              aligned, ahit;

  always_comb begin
    en[NUM_STAGES] = !v_q[NUM_STAGES] || out_ready_i;
    for (int k = NUM_STAGES - 1; k >= 1; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign in_ready_o = en[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[1]) v_q[1] <= in_valid_i;
      for (int k = 2; k <= NUM_STAGES; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  always_comb begin
    a_r     = (W+1)'(a_left_i) + (W+1)'($signed({1'b0, a_width_i}));
    a_b     = (W+1)'(a_top_i) + (W+1)'($signed({1'b0, a_height_i}));
    b_r     = (W+1)'(b_left_i) + (W+1)'($signed({1'b0, b_width_i}));
    b_b     = (W+1)'(b_top_i) + (W+1)'($signed({1'b0, b_height_i}));
    ahit    = ((W+1)'(b_left_i) < a_r) && (b_r > (W+1)'(a_left_i))
           && ((W+1)'(b_top_i) < a_b) && (b_b > (W+1)'(a_top_i));
    aligned = (a_angle_i == '0 || a_angle_i == angle_t'(DEG_FULL))
           && (b_angle_i == '0 || b_angle_i == angle_t'(DEG_FULL));
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      al_q[1] <= aligned;
      ah_q[1] <= ahit;
    end
    for (int k = 2; k <= 7; k++) begin
      if (en[k]) begin
        al_q[k] <= al_q[k-1];
        ah_q[k] <= ah_q[k-1];
      end
    end
  end

  rrc_corner #(.W(W), .T(TRIG_FRAC_BITS), .CRW(CRW)) u_corner_a (
    .clk_i   (clk_i),
    .en_i    (en),
    .left_i  (a_left_i),
    .top_i   (a_top_i),
    .width_i (a_width_i),
    .height_i(a_height_i),
    .angle_i (a_angle_i),
    .x_o     (cxa),
    .y_o     (cya)
  );

  rrc_corner #(.W(W), .T(TRIG_FRAC_BITS), .CRW(CRW)) u_corner_b (
    .clk_i   (clk_i),
    .en_i    (en),
    .left_i  (b_left_i),
    .top_i   (b_top_i),
    .width_i (b_width_i),
    .height_i(b_height_i),
    .angle_i (b_angle_i),
    .x_o     (cxb),
    .y_o     (cyb)
  );

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      cx[k]   = cxa[k];
      cy[k]   = cya[k];
      cx[k+4] = cxb[k];
      cy[k+4] = cyb[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      cx4_q    <= cx;
      cy4_q    <= cy;
      axx_q[0] <= AXW'(cx[1]) - AXW'(cx[0]);
      axy_q[0] <= AXW'(cy[1]) - AXW'(cy[0]);
      axx_q[1] <= AXW'(cx[1]) - AXW'(cx[3]);
      axy_q[1] <= AXW'(cy[1]) - AXW'(cy[3]);
      axx_q[2] <= AXW'(cx[4]) - AXW'(cx[6]);
      axy_q[2] <= AXW'(cy[4]) - AXW'(cy[6]);
      axx_q[3] <= AXW'(cx[4]) - AXW'(cx[5]);
      axy_q[3] <= AXW'(cy[4]) - AXW'(cy[5]);
    end
  end

  for (genvar i = 0; i < 4; i++) begin : g_axis
    rrc_proj #(.CRW(CRW), .AXW(AXW), .K(2 * COORD_FRAC_BITS)) u_proj (
      .clk_i(clk_i),
      .en_i (en),
      .ax_i (axx_q[i]),
      .ay_i (axy_q[i]),
      .x_i  (cx4_q),
      .y_i  (cy4_q),
      .sep_o(sep[i])
    );
  end

  always_ff @(posedge clk_i) begin
    if (en[8]) begin
      overlap_q <= al_q[7] ? ah_q[7] : !(|sep);
    end
  end

  assign out_valid_o = v_q[NUM_STAGES];
  assign overlap_o   = overlap_q;

  `RRC_ASSERT_NXT(a_in_enters, in_valid_i && in_ready_o, v_q[1], "accepted query not in stage 1")
  `RRC_ASSERT_IMP(a_ready_full, !in_ready_o, v_q[1] && v_q[2], "input stall with free slot")
  `RRC_ASSERT_NXT(a_stall_hold, v_q[7] && !en[8], v_q[7], "stalled stage 7 lost its item")

endmodule

@@ rtl/core/rrc_corner.sv @@
// Rectangle corner rotation pipeline: trig lookup, products, corner sums
module rrc_corner #(
  parameter int W = 24,
  parameter int T = 14,
  parameter int CRW = W + 3
) (
  input  logic                    clk_i,
  input  rrc_pkg::stage_en_t      en_i,
  input  logic signed [W-1:0]     left_i,
  input  logic signed [W-1:0]     top_i,
  input  logic [W-2:0]            width_i,
  input  logic [W-2:0]            height_i,
  input  rrc_pkg::angle_t         angle_i,
  output logic signed [CRW-1:0]   x_o [4],
  output logic signed [CRW-1:0]   y_o [4]
);
  import rrc_pkg::*;

  localparam int PW = W + TRIG_W;
  localparam int XW = W + 20;

  angle_t ang, cang, cang_raw;

  logic signed [W-1:0] left_q, top_q;
  logic [W-2:0]        w_q, h_q;
  trig_t               sin_q, cos_q;

  logic signed [PW-1:0] wc_q, ws_q, hc_q, hs_q;
  logic signed [XW-1:0] cx_q, cy_q;

  logic signed [XW-1:0] cx_d, cy_d, one, wc, ws, hc, hs;
  logic signed [XW-1:0] x2 [4];
  logic signed [XW-1:0] y2 [4];

  always_comb begin
    ang      = (angle_i >= angle_t'(DEG_FULL)) ? angle_i - angle_t'(DEG_FULL) : angle_i;
    cang_raw = ang + angle_t'(DEG_QUARTER);
    cang     = (cang_raw >= angle_t'(DEG_FULL)) ? cang_raw - angle_t'(DEG_FULL) : cang_raw;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      left_q <= left_i;
      top_q  <= top_i;
      w_q    <= width_i;
      h_q    <= height_i;
      sin_q  <= sine_deg(ang, T);
      cos_q  <= sine_deg(cang, T);
    end
  end

  always_comb begin
    cx_d = ((XW'(left_q) <<< 1) + XW'($signed({1'b0, w_q}))) <<< T;
    cy_d = ((XW'(top_q) <<< 1) + XW'($signed({1'b0, h_q}))) <<< T;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      wc_q <= $signed({1'b0, w_q}) * cos_q;
      ws_q <= $signed({1'b0, w_q}) * sin_q;
      hc_q <= $signed({1'b0, h_q}) * cos_q;
      hs_q <= $signed({1'b0, h_q}) * sin_q;
      cx_q <= cx_d;
      cy_q <= cy_d;
    end
  end

  always_comb begin
    one   = XW'(1) <<< T;
    wc    = XW'(wc_q);
    ws    = XW'(ws_q);
    hc    = XW'(hc_q);
    hs    = XW'(hs_q);
    x2[0] = cx_q - wc + hs + one;
    y2[0] = cy_q - hc - ws + one;
    x2[1] = cx_q + wc + hs + one;
    y2[1] = cy_q - hc + ws + one;
    x2[2] = cx_q - wc - hs + one;
    y2[2] = cy_q + hc - ws + one;
    x2[3] = cx_q + wc - hs + one;
    y2[3] = cy_q + hc + ws + one;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      for (int i = 0; i < 4; i++) begin
        x_o[i] <= x2[i][CRW+T:T+1];
        y_o[i] <= y2[i][CRW+T:T+1];
      end
    end
  end

endmodule

@@ rtl/core/rrc_proj.sv @@
// Projection of all corners onto one axis and separation test
module rrc_proj #(
  parameter int CRW = 27,
  parameter int AXW = 28,
  parameter int K   = 16
) (
  input  logic                   clk_i,
  input  rrc_pkg::stage_en_t     en_i,
  input  logic signed [AXW-1:0]  ax_i,
  input  logic signed [AXW-1:0]  ay_i,
  input  logic signed [CRW-1:0]  x_i [8],
  input  logic signed [CRW-1:0]  y_i [8],
  output logic                   sep_o
);
  import rrc_pkg::*;

  localparam int MW  = CRW + AXW;
  localparam int PSW = MW + 1;
  localparam int PJW = (PSW > 63) ? PSW : 64;

  logic signed [MW-1:0]  px_q [8];
  logic signed [MW-1:0]  py_q [8];
  logic signed [PJW-1:0] proj_q [8];
  logic signed [PJW-1:0] proj_d [8];
  logic signed [PJW-1:0] mna_q, mxa_q, mnb_q, mxb_q;
  logic signed [PJW-1:0] mna, mxa, mnb, mxb, lim;
  logic signed [PSW-1:0] sum, bias, shr;

  always_ff @(posedge clk_i) begin
    if (en_i[5]) begin
      for (int k = 0; k < 8; k++) begin
        px_q[k] <= x_i[k] * ax_i;
        py_q[k] <= y_i[k] * ay_i;
      end
    end
  end

  always_comb begin
    lim = PJW'(1) <<< 62;
    sum = '0;
    bias = '0;
    shr = '0;
    for (int k = 0; k < 8; k++) begin
      sum  = PSW'(px_q[k]) + PSW'(py_q[k]);
      bias = {PSW{sum[PSW-1]}} & ((PSW'(1) << K) - PSW'(1));
      shr  = (sum + bias) >>> K;
      if (PJW'(shr) > lim) begin
        proj_d[k] = lim;
      end else if (PJW'(shr) < -lim) begin
        proj_d[k] = -lim;
      end else begin
        proj_d[k] = PJW'(shr);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[6]) begin
      proj_q <= proj_d;
    end
  end

  always_comb begin
    mna = proj_q[0];
    mxa = proj_q[0];
    mnb = proj_q[4];
    mxb = proj_q[4];
    for (int k = 1; k < 4; k++) begin
      if (proj_q[k] < mna) mna = proj_q[k];
      if (proj_q[k] > mxa) mxa = proj_q[k];
      if (proj_q[k+4] < mnb) mnb = proj_q[k+4];
      if (proj_q[k+4] > mxb) mxb = proj_q[k+4];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[7]) begin
      mna_q <= mna;
      mxa_q <= mxa;
      mnb_q <= mnb;
      mxb_q <= mxb;
    end
  end

  assign sep_o = !((mnb_q <= mxa_q) && (mxb_q >= mna_q));

endmodule
